// ===== rtl/core/tasp_pkg.sv =====
// ----------------------------------------------------------------------------
// tasp_pkg
// Shared types and constants for the two-axis step pulse generator.
// ----------------------------------------------------------------------------
package tasp_pkg;

  localparam int SPEED_BITS   = 8;
  localparam int TICK_BITS    = 8;
  localparam int OUT_POS_BITS = 32;
  localparam int DIV_STEPS    = SPEED_BITS;
  localparam logic [SPEED_BITS-1:0] SPEED_FULL = '1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FWD  = 2'd1,
    OP_REV  = 2'd2,
    OP_STOP = 2'd3
  } op_t;

  localparam logic AXIS_LINEAR  = 1'b0;
  localparam logic AXIS_ANGULAR = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/tasp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tasp_ctrl
// Sequencer: accept a beat, run the interval divider for run commands,
// apply the beat to the axis state and hold the result beat.
// ----------------------------------------------------------------------------
module tasp_ctrl
  import tasp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  output logic       out_valid,
  input  logic       out_stall,
  output ctrl_cmd_t  cmd
);

  localparam int CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC,
    S_HOLD
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] step_cnt;
  logic                is_run;

  assign is_run   = (opcode == OP_FWD) || (opcode == OP_REV);
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.exec     = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            step_cnt <= '0;
            state    <= is_run ? S_DIV : S_EXEC;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == CNT_LAST) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid <= 1'b1;
          state     <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tasp_dpath.sv =====
// ----------------------------------------------------------------------------
// tasp_dpath
// Axis state, bit-serial interval divider and result registers.
// ----------------------------------------------------------------------------
module tasp_dpath
  import tasp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic [1:0]              opcode,
  input  logic                    axis,
  input  logic [SPEED_BITS-1:0]   speed_code,
  output logic                    linear_step,
  output logic                    linear_dir,
  output logic                    angular_step,
  output logic                    angular_dir,
  output logic [OUT_POS_BITS-1:0] linear_position,
  output logic [OUT_POS_BITS-1:0] angular_position
);

  op_t                   op_q;
  logic                  axis_q;
  logic [SPEED_BITS-1:0] code_q;
  logic [SPEED_BITS-1:0] div_rem;
  logic [SPEED_BITS-1:0] div_quo;
  logic [SPEED_BITS:0]   rem_shift;
  logic                  rem_ge;

  logic [SPEED_BITS-1:0]    interval [2];
  logic                     halted   [2];
  logic                     forward  [2];
  logic [TICK_BITS-1:0]     ticks    [2];
  logic [POSITION_BITS-1:0] count    [2];
  logic                     pin_dir  [2];
  logic                     step     [2];
  logic [TICK_BITS-1:0]     ticks_next [2];
  logic                     fire     [2];

  assign rem_shift = {div_rem, div_quo[SPEED_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, code_q});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(opcode);
      axis_q  <= axis;
      code_q  <= speed_code;
      div_rem <= '0;
      div_quo <= SPEED_FULL;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? SPEED_BITS'(rem_shift - {1'b0, code_q})
                        : rem_shift[SPEED_BITS-1:0];
      div_quo <= {div_quo[SPEED_BITS-2:0], rem_ge};
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_axis
    localparam logic AX_ID   = (i == 1) ? AXIS_ANGULAR : AXIS_LINEAR;
    localparam logic FWD_RST = (i == 1);

    assign ticks_next[i] = ticks[i] + 1'b1;
    assign fire[i]       = (ticks_next[i] >= interval[i]) && !halted[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        interval[i] <= '0;
        halted[i]   <= 1'b0;
        forward[i]  <= FWD_RST;
        ticks[i]    <= '0;
        count[i]    <= '0;
        pin_dir[i]  <= 1'b0;
        step[i]     <= 1'b0;
      end else if (cmd.exec) begin
        step[i] <= 1'b0;
        if (op_q == OP_TICK) begin
          step[i] <= fire[i];
          if (fire[i]) begin
            pin_dir[i] <= forward[i];
            ticks[i]   <= '0;
            count[i]   <= forward[i] ? count[i] + 1'b1 : count[i] - 1'b1;
          end else begin
            ticks[i] <= ticks_next[i];
          end
        end else if (axis_q == AX_ID) begin
          if (op_q == OP_STOP) begin
            halted[i] <= 1'b1;
          end else begin
            halted[i]   <= 1'b0;
            forward[i]  <= (op_q == OP_FWD);
            interval[i] <= div_quo;
          end
        end
      end
    end
  end

  if (POSITION_BITS >= OUT_POS_BITS) begin : g_pos_trunc
    assign linear_position  = count[0][OUT_POS_BITS-1:0];
    assign angular_position = count[1][OUT_POS_BITS-1:0];
  end else begin : g_pos_ext
    assign linear_position  = {{(OUT_POS_BITS-POSITION_BITS){1'b0}}, count[0]};
    assign angular_position = {{(OUT_POS_BITS-POSITION_BITS){1'b0}}, count[1]};
  end

  assign linear_step  = step[0];
  assign angular_step = step[1];
  assign linear_dir   = pin_dir[0];
  assign angular_dir  = pin_dir[1];

endmodule

// ===== rtl/core/two_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// two_axis_step_pulse_generator
// Step and direction generator for a linear and an angular stepper axis.
// ----------------------------------------------------------------------------
// Each input beat is a tick or a run/stop command for one axis, and each
// gives one output beat with both step pulses, direction pins and positions.
// One beat is handled at a time. A tick or stop beat is accepted, applied
// and presented; a run beat is accepted, then its step interval
// floor(255/speed_code) comes from a restoring divider that resolves one
// quotient bit per cycle, before it is applied and presented. A stalled
// output holds the beat until it is taken. Positions wrap modulo
// 2^POSITION_BITS; the ports carry the low 32 bits, zero-extended if fewer.
module two_axis_step_pulse_generator
  import tasp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              opcode,
  input  logic                    axis,
  input  logic [SPEED_BITS-1:0]   speed_code,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    linear_step,
  output logic                    linear_dir,
  output logic                    angular_step,
  output logic                    angular_dir,
  output logic [OUT_POS_BITS-1:0] linear_position,
  output logic [OUT_POS_BITS-1:0] angular_position
);

  ctrl_cmd_t cmd;

  tasp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tasp_dpath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .opcode           (opcode),
    .axis             (axis),
    .speed_code       (speed_code),
    .linear_step      (linear_step),
    .linear_dir       (linear_dir),
    .angular_step     (angular_step),
    .angular_dir      (angular_dir),
    .linear_position  (linear_position),
    .angular_position (angular_position)
  );

endmodule
